### rtl/assert_macros.svh
// Assertion macros shared by the median tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain condition checked at every rising clock edge outside reset.
`define SWMT_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication checked outside reset.
`define SWMT_IMPLY(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

`endif

### rtl/swmt_pkg.sv
// Shared types and constants of the sorted window median tracker.
`timescale 1ns / 1ps

package swmt_pkg;

	localparam int SAMPLE_W = 16;

	// value travelling along the chain, with its token
	typedef struct packed {
		logic                tok;
		logic [SAMPLE_W-1:0] carry;
	} wave_t;

	typedef enum logic {
		ST_IDLE,
		ST_BUSY
	} state_t;

endpackage

### rtl/swmt_cell.sv
// One entry of the sorted window, passing carried values to its neighbours.
`timescale 1ns / 1ps

module swmt_cell
	import swmt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  wave_t               up_in,
	input  wave_t               down_in,
	output wave_t               up_out,
	output wave_t               down_out,
	output logic [SAMPLE_W-1:0] value
);

	logic [SAMPLE_W-1:0] value_q;
	wave_t               up_q;
	wave_t               down_q;

	// an empty entry takes the carry and lets the same value travel on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
			up_q    <= '0;
			down_q  <= '0;
		end else begin
			up_q.tok   <= up_in.tok;
			down_q.tok <= down_in.tok && !up_in.tok;
			if (up_in.tok) begin
				value_q     <= up_in.carry;
				up_q.carry  <= (value_q == '0) ? up_in.carry : value_q;
			end else if (down_in.tok) begin
				value_q      <= down_in.carry;
				down_q.carry <= (value_q == '0) ? down_in.carry : value_q;
			end
		end
	end

	assign up_out   = up_q;
	assign down_out = down_q;
	assign value    = value_q;

endmodule

### rtl/swmt_locate.sv
// Insertion place search: picks the cell where the new word enters each wave.
`timescale 1ns / 1ps

module swmt_locate
	import swmt_pkg::*;
#(
	parameter int WINDOW_DEPTH = 17,
	parameter int MID          = 8
) (
	input  logic [SAMPLE_W-1:0]     sample,
	input  logic [SAMPLE_W-1:0]     win [WINDOW_DEPTH],
	output logic [WINDOW_DEPTH-1:0] start_up,
	output logic [WINDOW_DEPTH-1:0] start_down
);

	logic [WINDOW_DEPTH-1:0] hit_lo;
	logic [WINDOW_DEPTH-1:0] hit_hi;
	logic                    below;
	logic                    above;

	assign below = sample < win[MID];
	assign above = sample > win[MID];

	always_comb begin
		hit_lo     = '0;
		hit_hi     = '0;
		start_up   = '0;
		start_down = '0;
		for (int i = 1; i <= MID; i++) begin
			hit_lo[i] = (sample >= win[i-1]) && (sample <= win[i]);
		end
		for (int i = MID; i < WINDOW_DEPTH - 1; i++) begin
			hit_hi[i] = (sample >= win[i]) && (sample <= win[i+1]);
		end
		if (below) begin
			// highest match at or below the middle wins
			start_up[0] = ~|hit_lo;
			for (int i = 1; i <= MID; i++) begin
				start_up[i] = hit_lo[i] & ~|(hit_lo >> (i + 1));
			end
		end else if (above) begin
			// lowest match at or above the middle wins
			start_down[WINDOW_DEPTH-1] = ~|hit_hi;
			for (int i = MID; i < WINDOW_DEPTH - 1; i++) begin
				start_down[i] = hit_hi[i] & ~|(hit_hi << (WINDOW_DEPTH - i));
			end
		end else begin
			// equal to the middle: one copy each way, both ends drop
			start_up[MID]     = 1'b1;
			start_down[MID-1] = 1'b1;
		end
	end

endmodule

### rtl/sorted_window_median_tracker.sv
// Top level of the sorted window median tracker: cell chain, control and output register.
// From accepted word to result the carry wave walks one cell a cycle from the insertion place to
// the end of the chain; then its token clears and the output register loads. No new word is
// taken until the result is loaded; a result held at the output stalls the input.
// Reset (arst_n, async, active low) empties the window to all zero and drops any result.
`timescale 1ns / 1ps

module sorted_window_median_tracker
	import swmt_pkg::*;
#(
	parameter int WINDOW_DEPTH = 17,
	parameter int MID_INDEX    = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [SAMPLE_W-1:0]   s_axis_tdata,  // [15:0] sample
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [3*SAMPLE_W-1:0] m_axis_tdata   // [15:0] window_min, [31:16] window_median,
	                                             // [47:32] window_max
);

	`include "assert_macros.svh"

	localparam int MID = (MID_INDEX < WINDOW_DEPTH) ? MID_INDEX : WINDOW_DEPTH - 1;

	state_t                  state_q;
	state_t                  state_d;
	logic                    in_acc;
	logic                    load_out;
	logic                    in_flight;
	logic [WINDOW_DEPTH-1:0] start_up;
	logic [WINDOW_DEPTH-1:0] start_down;
	logic [WINDOW_DEPTH-1:0] tok_up;
	logic [WINDOW_DEPTH-1:0] tok_down;
	logic [SAMPLE_W-1:0]     win [WINDOW_DEPTH];
	wave_t                   up_w [WINDOW_DEPTH];
	wave_t                   down_w [WINDOW_DEPTH];
	wave_t                   up_in_w [WINDOW_DEPTH];
	wave_t                   down_in_w [WINDOW_DEPTH];
	logic                    out_valid_q;
	logic [3*SAMPLE_W-1:0]   out_data_q;

	assign in_acc = s_axis_tvalid && s_axis_tready;

	swmt_locate #(
		.WINDOW_DEPTH(WINDOW_DEPTH),
		.MID         (MID)
	) u_locate (
		.sample    (s_axis_tdata),
		.win       (win),
		.start_up  (start_up),
		.start_down(start_down)
	);

	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_lo
			assign up_in_w[i] = (in_acc && start_up[i]) ? wave_t'{1'b1, s_axis_tdata} : '0;
		end else begin : g_lo
			assign up_in_w[i] = (in_acc && start_up[i]) ? wave_t'{1'b1, s_axis_tdata}
			                                            : up_w[i-1];
		end
		if (i == WINDOW_DEPTH - 1) begin : g_hi
			assign down_in_w[i] = (in_acc && start_down[i]) ? wave_t'{1'b1, s_axis_tdata}
			                                                : '0;
		end else begin : g_hi
			assign down_in_w[i] = (in_acc && start_down[i]) ? wave_t'{1'b1, s_axis_tdata}
			                                                : down_w[i+1];
		end

		swmt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_in   (up_in_w[i]),
			.down_in (down_in_w[i]),
			.up_out  (up_w[i]),
			.down_out(down_w[i]),
			.value   (win[i])
		);

		assign tok_up[i]   = up_w[i].tok;
		assign tok_down[i] = down_w[i].tok;
	end

	assign in_flight = |tok_up || |tok_down;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_BUSY;
				end
			end
			ST_BUSY: begin
				// window is settled once no wave is left on the chain
				if (!in_flight && (!out_valid_q || m_axis_tready)) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= {win[WINDOW_DEPTH-1], win[MID], win[0]};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	`SWMT_IMPLY(a_no_accept_in_flight, in_flight, !s_axis_tready, "word accepted while a wave runs")
	`SWMT_IMPLY(a_idle_chain_quiet, state_q == ST_IDLE, !in_flight, "wave on chain while idle")
	`SWMT_IMPLY(a_single_entry, in_acc, $onehot(start_up) || $onehot(start_down),
		"insertion place not unique")
	`SWMT_CHECK(a_entry_direction, !in_acc || !(|start_up) || !(|start_down) ||
		(start_up[MID] && start_down[MID-1]), "both waves started away from the middle")

endmodule

### tb/median_window_checker.sv
// Checker for the median tracker: tracks the sorted window and compares every result word.
`timescale 1ns / 1ps

module median_window_checker
	import swmt_pkg::*;
#(
	parameter int WINDOW_DEPTH = 17,
	parameter int MID_INDEX    = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [SAMPLE_W-1:0]   s_axis_tdata,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [3*SAMPLE_W-1:0] m_axis_tdata,
	output int                    mismatches,
	output int                    outstanding
);

	localparam int MID = (MID_INDEX < WINDOW_DEPTH) ? MID_INDEX : WINDOW_DEPTH - 1;
	localparam int TOP = WINDOW_DEPTH - 1;

	// same packing as m_axis_tdata: min lowest, max highest
	typedef struct packed {
		logic [SAMPLE_W-1:0] hi;
		logic [SAMPLE_W-1:0] med;
		logic [SAMPLE_W-1:0] lo;
	} stats_t;

	logic [SAMPLE_W-1:0] window [WINDOW_DEPTH];
	stats_t              stats_due [$];
	stats_t              want;
	stats_t              got;

	// insert at pos, displaced values travel upwards; an empty entry passes the carry on
	function automatic void carry_up(input logic [SAMPLE_W-1:0] v, input int pos);
		logic [SAMPLE_W-1:0] carry;
		logic [SAMPLE_W-1:0] old;
		carry = v;
		for (int i = pos; i < WINDOW_DEPTH; i++) begin
			old       = window[i];
			window[i] = carry;
			carry     = (old == '0) ? carry : old;
		end
	endfunction

	function automatic void carry_down(input logic [SAMPLE_W-1:0] v, input int pos);
		logic [SAMPLE_W-1:0] carry;
		logic [SAMPLE_W-1:0] old;
		carry = v;
		for (int i = pos; i >= 0; i--) begin
			old       = window[i];
			window[i] = carry;
			carry     = (old == '0) ? carry : old;
		end
	endfunction

	function automatic stats_t insert_sample(input logic [SAMPLE_W-1:0] v);
		logic [SAMPLE_W-1:0] centre;
		int                  pos;
		bit                  found;
		centre = window[MID];
		found  = 1'b0;
		if (v < centre) begin
			pos = 0;
			for (int i = MID; i > 0 && !found; i--) begin
				if (v >= window[i-1] && v <= window[i]) begin
					pos   = i;
					found = 1'b1;
				end
			end
			carry_up(v, pos);
		end else if (v > centre) begin
			pos = TOP;
			for (int i = MID; i < TOP && !found; i++) begin
				if (v >= window[i] && v <= window[i+1]) begin
					pos   = i;
					found = 1'b1;
				end
			end
			carry_down(v, pos);
		end else begin
			// equal to the middle: both ends drop
			carry_up(v, MID);
			carry_down(v, MID);
		end
		return '{hi: window[TOP], med: window[MID], lo: window[0]};
	endfunction

	task automatic report(input string msg);
		mismatches++;
		$display("MISMATCH at %0t ns: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_DEPTH; i++)
				window[i] = '0;
			stats_due.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			// a result word can never belong to a word accepted at the same edge
			if (m_axis_tvalid && m_axis_tready) begin
				if (stats_due.size() == 0) begin
					report($sformatf("result word %h with nothing expected", m_axis_tdata));
				end else begin
					want = stats_due.pop_front();
					got  = m_axis_tdata;
					if (got.lo !== want.lo)
						report($sformatf("window_min got %h want %h", got.lo, want.lo));
					if (got.med !== want.med)
						report($sformatf("window_median got %h want %h", got.med, want.med));
					if (got.hi !== want.hi)
						report($sformatf("window_max got %h want %h", got.hi, want.hi));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				stats_due.push_back(insert_sample(s_axis_tdata));
			outstanding = stats_due.size();
		end
	end

endmodule

### tb/tb.sv
// Testbench top for the median tracker: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;
	import swmt_pkg::*;

	localparam int DEPTH     = 17;
	localparam int MID       = 8;
	localparam int PER_STAGE = 460;
	localparam int HOLD_AT   = 1100;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [SAMPLE_W-1:0]   s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [3*SAMPLE_W-1:0] m_axis_tdata;

	int mismatches;
	int outstanding;
	int tx_idle_pct = 11;
	int rx_idle_pct = 72;
	int words_sent  = 0;

	sorted_window_median_tracker #(
		.WINDOW_DEPTH(DEPTH),
		.MID_INDEX   (MID)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	median_window_checker #(
		.WINDOW_DEPTH(DEPTH),
		.MID_INDEX   (MID)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic send_sample(input logic [SAMPLE_W-1:0] v);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	// mostly full range; clusters round a base value give duplicates and middle hits
	function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] base);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return SAMPLE_W'($urandom);
		else if (roll < 80)
			return base + SAMPLE_W'($urandom_range(0, 3));
		else if (roll < 90)
			return '0;
		else if (roll < 95)
			return '1;
		else
			return SAMPLE_W'($urandom_range(1, 3));
	endfunction

	// receiver: random back-pressure, plus one long hold-off while the sender keeps going
	initial begin
		int hold_left;
		bit held;
		hold_left     = 0;
		held          = 1'b0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!held && words_sent >= HOLD_AT) begin
				held      = 1'b1;
				hold_left = 500;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		logic [SAMPLE_W-1:0] directed [$];
		logic [SAMPLE_W-1:0] base;
		int                  waited;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// extremes, zero into an empty window, bit patterns, runs of one value, both orders
		directed = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF,
			16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00,
			16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h4000,
			16'h3000, 16'h2000, 16'h1000, 16'h9000, 16'hA000, 16'hB000};
		foreach (directed[i])
			send_sample(directed[i]);

		base = SAMPLE_W'($urandom);
		for (int stage = 0; stage < 3; stage++) begin
			case (stage)
				0: begin
					tx_idle_pct = 11;
					rx_idle_pct = 72;
				end
				1: begin
					tx_idle_pct = 72;
					rx_idle_pct = 11;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < PER_STAGE; n++) begin
				if (n % 40 == 0)
					base = SAMPLE_W'($urandom);
				send_sample(pick_sample(base));
			end
		end
		s_axis_tvalid <= 1'b0;

		waited = 0;
		while (outstanding != 0 && waited < 20000) begin
			@(negedge clk);
			waited++;
		end
		repeat (DEPTH + 20) @(negedge clk);

		if (mismatches == 0 && outstanding == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

### sorted_window_median_tracker.f
+incdir+rtl
rtl/swmt_pkg.sv
rtl/swmt_cell.sv
rtl/swmt_locate.sv
rtl/sorted_window_median_tracker.sv
tb/median_window_checker.sv
tb/tb.sv
